### rtl/slr_pkg.sv
package slr_pkg;

    localparam int MAX_SAMPLES_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int RESULT_BITS_DEF  = 48;
    localparam int FIELD_BITS       = 16;
    localparam int COUNT_OUT_BITS   = 13;

    // product pairs of the normal equations, in the order they are formed
    typedef enum logic [2:0] {
        PR_N_SXX  = 3'd0,
        PR_SX_SX  = 3'd1,
        PR_SXX_SY = 3'd2,
        PR_SX_SXY = 3'd3,
        PR_N_SXY  = 3'd4,
        PR_SX_SY  = 3'd5
    } t_prod;

    typedef struct packed {
        logic  acc_en;
        logic  mul_load;
        logic  mul_step;
        logic  mul_store;
        t_prod op;
        logic  div_load;
        logic  div_step;
        logic  div_store;
        logic  div_sel;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic det_zero;
        logic out_busy;
    } t_status;

endpackage

### rtl/slr_ctrl.sv
module slr_ctrl #(
    parameter int MUL_CYCLES = 45,
    parameter int DIV_CYCLES = 107
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tlast,
    output logic             o_s_tready,
    input  slr_pkg::t_status i_status,
    output slr_pkg::t_cmd    o_cmd
);

    localparam int MAXC = (MUL_CYCLES > DIV_CYCLES) ? MUL_CYCLES : DIV_CYCLES;
    localparam int CYW  = $clog2(MAXC + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_LD, ST_MUL_RUN, ST_MUL_ST,
        ST_DIV_LD, ST_DIV_RUN, ST_DIV_ST, ST_OUT
    } t_state;

    t_state         r_state;
    slr_pkg::t_prod r_op;
    logic           r_sel;
    logic [CYW-1:0] r_cyc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= slr_pkg::PR_N_SXX;
            r_sel   <= 1'b0;
            r_cyc   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid && i_s_tlast) begin
                        r_state <= ST_MUL_LD;
                        r_op    <= slr_pkg::PR_N_SXX;
                    end
                end
                ST_MUL_LD: begin
                    r_cyc   <= '0;
                    r_state <= ST_MUL_RUN;
                end
                ST_MUL_RUN: begin
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == CYW'(MUL_CYCLES - 1)) r_state <= ST_MUL_ST;
                end
                ST_MUL_ST: begin
                    if (r_op == slr_pkg::PR_SX_SY) begin
                        r_sel   <= 1'b0;
                        r_state <= i_status.det_zero ? ST_OUT : ST_DIV_LD;
                    end else begin
                        r_op    <= slr_pkg::t_prod'(r_op + 3'd1);
                        r_state <= ST_MUL_LD;
                    end
                end
                ST_DIV_LD: begin
                    r_cyc   <= '0;
                    r_state <= ST_DIV_RUN;
                end
                ST_DIV_RUN: begin
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == CYW'(DIV_CYCLES - 1)) r_state <= ST_DIV_ST;
                end
                ST_DIV_ST: begin
                    if (r_sel) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_sel   <= 1'b1;
                        r_state <= ST_DIV_LD;
                    end
                end
                ST_OUT: begin
                    if (!i_status.out_busy) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.div_sel   = r_sel;
        o_cmd.acc_en    = i_s_tvalid && (r_state == ST_IDLE);
        o_cmd.mul_load  = (r_state == ST_MUL_LD);
        o_cmd.mul_step  = (r_state == ST_MUL_RUN);
        o_cmd.mul_store = (r_state == ST_MUL_ST);
        o_cmd.div_load  = (r_state == ST_DIV_LD);
        o_cmd.div_step  = (r_state == ST_DIV_RUN);
        o_cmd.div_store = (r_state == ST_DIV_ST);
        o_cmd.out_load  = (r_state == ST_OUT) && !i_status.out_busy;
    end

endmodule

### rtl/slr_dp.sv
module slr_dp #(
    parameter int MAX_SAMPLES = slr_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = slr_pkg::FRAC_BITS_DEF,
    parameter int RESULT_BITS = slr_pkg::RESULT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [slr_pkg::FIELD_BITS-1:0]      i_x,
    input  logic [slr_pkg::FIELD_BITS-1:0]      i_y,
    input  slr_pkg::t_cmd                       i_cmd,
    output slr_pkg::t_status                    o_status,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [RESULT_BITS-1:0]              o_intercept,
    output logic [RESULT_BITS-1:0]              o_slope,
    output logic                                o_singular,
    output logic                                o_overflow,
    output logic [slr_pkg::COUNT_OUT_BITS-1:0]  o_sample_count
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SXW = SAMPLE_BITS + CW;
    localparam int AW  = 2 * SAMPLE_BITS + CW;
    localparam int PW  = 2 * AW;
    localparam int DW  = PW + 1;
    localparam int NW  = DW + FRAC_BITS;
    localparam int EW  = ((NW > RESULT_BITS) ? NW : RESULT_BITS) + 1;

    // accumulators
    logic        [CW-1:0]  r_cnt;
    logic signed [SXW-1:0] r_sx, r_sy;
    logic signed [AW-1:0]  r_sxx, r_sxy;
    logic                  r_drop;

    logic signed [SAMPLE_BITS-1:0]   xs, ys;
    logic signed [2*SAMPLE_BITS-1:0] pxx, pxy;

    assign xs  = SAMPLE_BITS'(signed'(i_x));
    assign ys  = SAMPLE_BITS'(signed'(i_y));
    assign pxx = xs * xs;
    assign pxy = xs * ys;

    // shift-add multiplier
    logic [AW-1:0] r_ma, r_mb;
    logic [PW-1:0] r_acc;
    logic          r_mneg;
    logic signed [AW-1:0] opa, opb;
    logic signed [DW-1:0] prod, r_tmp;
    logic signed [DW-1:0] r_det, r_num0, r_num1;

    always_comb begin
        opa = AW'(signed'({1'b0, r_cnt}));
        opb = r_sxx;
        case (i_cmd.op)
            slr_pkg::PR_N_SXX:  begin opa = AW'(signed'({1'b0, r_cnt})); opb = r_sxx;     end
            slr_pkg::PR_SX_SX:  begin opa = AW'(r_sx);  opb = AW'(r_sx);                  end
            slr_pkg::PR_SXX_SY: begin opa = r_sxx;      opb = AW'(r_sy);                  end
            slr_pkg::PR_SX_SXY: begin opa = AW'(r_sx);  opb = r_sxy;                      end
            slr_pkg::PR_N_SXY:  begin opa = AW'(signed'({1'b0, r_cnt})); opb = r_sxy;     end
            slr_pkg::PR_SX_SY:  begin opa = AW'(r_sx);  opb = AW'(r_sy);                  end
            default:            begin opa = '0;         opb = '0;                         end
        endcase
    end

    assign prod = r_mneg ? -signed'({1'b0, r_acc}) : signed'({1'b0, r_acc});

    // restoring divider
    logic [NW-1:0] r_dn, r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_dd;
    logic          r_dneg;
    logic [DW:0]   trial;
    logic          ge;
    logic signed [DW-1:0] num_sel;
    logic [DW-1:0] num_mag, det_mag;
    logic [EW-1:0] qe, lim, qmag;
    logic          qsat;
    logic [RESULT_BITS-1:0] qres;
    logic [RESULT_BITS-1:0] r_icpt, r_slope;
    logic          r_sat;

    assign num_sel = i_cmd.div_sel ? r_num1 : r_num0;
    assign num_mag = num_sel[DW-1] ? DW'(-num_sel) : DW'(num_sel);
    assign det_mag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
    assign trial   = {r_rem[DW-1:0], r_dn[NW-1]};
    assign ge      = (trial >= {1'b0, r_dd});

    always_comb begin
        qe  = EW'(r_q);
        lim = EW'(1) << (RESULT_BITS - 1);
        if (r_dneg) begin
            qsat = (qe > lim);
            qmag = qsat ? lim : qe;
        end else begin
            qsat = (qe > lim - 1'b1);
            qmag = qsat ? lim - 1'b1 : qe;
        end
        qres = r_dneg ? RESULT_BITS'(-qmag) : RESULT_BITS'(qmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_sx       <= '0;
            r_sy       <= '0;
            r_sxx      <= '0;
            r_sxy      <= '0;
            r_drop     <= 1'b0;
            r_sat      <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                o_m_tvalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            if (i_cmd.acc_en) begin
                if (r_cnt == CW'(MAX_SAMPLES)) begin
                    r_drop <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sx  <= r_sx + SXW'(xs);
                    r_sy  <= r_sy + SXW'(ys);
                    r_sxx <= r_sxx + AW'(pxx);
                    r_sxy <= r_sxy + AW'(pxy);
                end
            end
            if (i_cmd.div_store && qsat) r_sat <= 1'b1;
            if (i_cmd.out_load) begin
                r_cnt      <= '0;
                r_sx       <= '0;
                r_sy       <= '0;
                r_sxx      <= '0;
                r_sxy      <= '0;
                r_drop     <= 1'b0;
                r_sat      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_ma   <= opa[AW-1] ? AW'(-opa) : AW'(opa);
            r_mb   <= opb[AW-1] ? AW'(-opb) : AW'(opb);
            r_mneg <= opa[AW-1] ^ opb[AW-1];
            r_acc  <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc <= (r_acc << 1) + (r_mb[AW-1] ? PW'(r_ma) : '0);
            r_mb  <= r_mb << 1;
        end
        if (i_cmd.mul_store) begin
            // even product held, odd product subtracted from it
            case (i_cmd.op)
                slr_pkg::PR_SX_SX:  r_det  <= r_tmp - prod;
                slr_pkg::PR_SX_SXY: r_num0 <= r_tmp - prod;
                slr_pkg::PR_SX_SY:  r_num1 <= r_tmp - prod;
                default:            r_tmp  <= prod;
            endcase
        end
        if (i_cmd.div_load) begin
            r_dn   <= NW'(num_mag) << FRAC_BITS;
            r_dd   <= det_mag;
            r_dneg <= num_sel[DW-1] ^ r_det[DW-1];
            r_rem  <= '0;
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? trial - {1'b0, r_dd} : trial;
            r_dn  <= r_dn << 1;
            r_q   <= {r_q[NW-2:0], ge};
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel) r_slope <= qres;
            else               r_icpt  <= qres;
        end
        if (i_cmd.out_load) begin
            o_intercept    <= o_status.det_zero ? '0 : r_icpt;
            o_slope        <= o_status.det_zero ? '0 : r_slope;
            o_singular     <= o_status.det_zero;
            o_overflow     <= r_drop || (!o_status.det_zero && r_sat);
            o_sample_count <= slr_pkg::COUNT_OUT_BITS'(r_cnt);
        end
    end

    assign o_status.det_zero = (r_det == '0);
    assign o_status.out_busy = o_m_tvalid && !i_m_tready;

endmodule

### rtl/simple_linear_regression_core.sv
// After the last pair, the bit-serial multiplier forms the six normal-equation
//   products on AW = 2*SAMPLE_BITS + clog2(MAX_SAMPLES+1) bit operands, then the
//   restoring divider forms intercept and slope on NW = 2*AW + 1 + FRAC_BITS bits.
// A singular fit skips the divider. A waiting result holds the fit.
// Throughput: one pair per cycle while accumulating; no pairs are taken during a fit.
// Reset (i_rst_n low, synchronous) clears all sums, the count and the output valid.
module simple_linear_regression_core #(
    parameter int MAX_SAMPLES = slr_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = slr_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = slr_pkg::FRAC_BITS_DEF,
    parameter int RESULT_BITS = slr_pkg::RESULT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,  // x_sample, y_sample
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [((2*RESULT_BITS+slr_pkg::COUNT_OUT_BITS+7)/8)*8-1:0] o_m_tdata,
                                             // intercept, slope, sample_count
    output logic [1:0]           o_m_tuser   // singular, overflow
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = 2 * SAMPLE_BITS + CW;
    localparam int NW  = 2 * AW + 1 + FRAC_BITS;
    localparam int OTW = ((2 * RESULT_BITS + slr_pkg::COUNT_OUT_BITS + 7) / 8) * 8;

    slr_pkg::t_cmd    cmd;
    slr_pkg::t_status status;

    logic [RESULT_BITS-1:0]             icpt, slope;
    logic                               singular, overflow;
    logic [slr_pkg::COUNT_OUT_BITS-1:0] count;

    slr_ctrl #(
        .MUL_CYCLES (AW),
        .DIV_CYCLES (NW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    slr_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_x            (i_s_tdata[15:0]),
        .i_y            (i_s_tdata[31:16]),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_intercept    (icpt),
        .o_slope        (slope),
        .o_singular     (singular),
        .o_overflow     (overflow),
        .o_sample_count (count)
    );

    assign o_m_tdata = OTW'({count, slope, icpt});
    assign o_m_tuser = {overflow, singular};

    // the last pair of a set starts a fit and closes the input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after last pair");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (icpt == '0 && slope == '0))
        else $error("singular fit with nonzero coefficients");

    a_fit_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mul_step || cmd.div_step) |-> !o_s_tready)
        else $error("pair taken during a fit");

endmodule

### bench/testbench.sv
module testbench;

    localparam int RB = slr_pkg::RESULT_BITS_DEF;
    localparam int OUT_W = ((2*RB+slr_pkg::COUNT_OUT_BITS+7)/8)*8;
    localparam int FIT_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [RB-1:0]                      intercept;
        logic [RB-1:0]                      slope;
        logic                               singular;
        logic                               overflow;
        logic [slr_pkg::COUNT_OUT_BITS-1:0] count;
    } t_fit;

    class fit_scoreboard;
        longint cnt, sx, sy, sxx, sxy;
        bit     dropped;
        t_fit   fits_due[$];
        int     errors;

        function void clear_sums();
            cnt = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; dropped = 0;
        endfunction

        function t_wide wd(longint v);
            t_wide r;
            r = v;
            return r;
        endfunction

        // trunc(num * 2^FRAC / det), saturated to the result width
        function logic [RB-1:0] quot(t_wide num, t_wide den, inout bit sat);
            t_wide q, hi, lo;
            hi = (t_wide'(1) <<< (RB-1)) - 1;
            lo = -(t_wide'(1) <<< (RB-1));
            q = (num * (t_wide'(1) <<< slr_pkg::FRAC_BITS_DEF)) / den;
            if (q > hi) begin
                sat = 1; q = hi;
            end else if (q < lo) begin
                sat = 1; q = lo;
            end
            return q[RB-1:0];
        endfunction

        function void note_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
            t_wide det, num0, num1;
            t_fit  f;
            bit    sat;
            longint xv, yv;
            xv = x; yv = y; sat = 0;
            if (cnt >= slr_pkg::MAX_SAMPLES_DEF) begin
                dropped = 1;
            end else begin
                cnt++; sx += xv; sy += yv; sxx += xv*xv; sxy += xv*yv;
            end
            if (!last) return;
            det  = wd(cnt)*wd(sxx) - wd(sx)*wd(sx);
            num0 = wd(sxx)*wd(sy) - wd(sx)*wd(sxy);
            num1 = wd(cnt)*wd(sxy) - wd(sx)*wd(sy);
            if (det == 0) begin
                f.intercept = '0; f.slope = '0; f.singular = 1;
            end else begin
                f.intercept = quot(num0, det, sat);
                f.slope     = quot(num1, det, sat);
                f.singular  = 0;
            end
            f.overflow = dropped | sat;
            f.count    = cnt[slr_pkg::COUNT_OUT_BITS-1:0];
            fits_due = {fits_due, f};
            clear_sums();
        endfunction

        function void check_fit(logic [OUT_W-1:0] d, logic [1:0] u);
            t_fit e;
            if (fits_due.size() == 0) begin
                $display("%0t: unexpected result intercept=%h slope=%h", $time,
                         d[RB-1:0], d[2*RB-1:RB]);
                errors++;
                return;
            end
            e = fits_due.pop_front();
            if (d[RB-1:0] !== e.intercept) begin
                $display("%0t: intercept exp %h got %h", $time, e.intercept, d[RB-1:0]);
                errors++;
            end
            if (d[2*RB-1:RB] !== e.slope) begin
                $display("%0t: slope exp %h got %h", $time, e.slope, d[2*RB-1:RB]);
                errors++;
            end
            if (d[2*RB+slr_pkg::COUNT_OUT_BITS-1:2*RB] !== e.count) begin
                $display("%0t: count exp %0d got %0d", $time, e.count,
                         d[2*RB+slr_pkg::COUNT_OUT_BITS-1:2*RB]);
                errors++;
            end
            if (u[0] !== e.singular) begin
                $display("%0t: singular exp %b got %b", $time, e.singular, u[0]);
                errors++;
            end
            if (u[1] !== e.overflow) begin
                $display("%0t: overflow exp %b got %b", $time, e.overflow, u[1]);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [31:0]      i_s_tdata;   // x_sample, y_sample
    logic             i_s_tlast;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // intercept, slope, sample_count
    logic [1:0]       o_m_tuser;   // singular, overflow

    simple_linear_regression_core i_dut (.*);

    fit_scoreboard sb;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    longint cycles = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready = 0;
            end else begin
                i_m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_fit(o_m_tdata, o_m_tuser);

    task send_pair(logic [15:0] x, logic [15:0] y, bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1;
        i_s_tdata  = {y, x};
        i_s_tlast  = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_pair(x, y, last);
    endtask

    task send_random_set(int len, int spread);
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            if (spread == 0)
                send_pair(base, 16'($urandom), i == len-1);
            else if (spread < 0)
                send_pair(16'($urandom), 16'($urandom), i == len-1);
            else
                send_pair(base + 16'($urandom_range(spread)), 16'($urandom), i == len-1);
        end
    endtask

    task set_phase(int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    initial begin
        sb = new();
        sb.clear_sums();
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tlast = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // single pair: singular
        send_pair(16'h0005, 16'h0007, 1);
        // equal x values: singular
        send_pair(16'h8000, 16'h7fff, 0);
        send_pair(16'h8000, 16'h8000, 1);
        // exact line y = 3x + 2
        for (int i = 0; i < 4; i++)
            send_pair(16'(i), 16'(3*i + 2), i == 3);
        // extremes
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h7fff, 16'h7fff, 0);
        send_pair(16'h0000, 16'hffff, 1);
        // large negative intercept
        send_pair(16'h7ffe, 16'h8000, 0);
        send_pair(16'h7fff, 16'h7fff, 1);
        // negative side
        send_pair(16'hffff, 16'h8000, 0);
        send_pair(16'h0000, 16'h7fff, 1);

        for (int p = 0; p < 8; p++) begin
            set_phase(p);
            if (p == 5) hold_cycles = 3000;
            for (int s = 0; s < 8; s++) begin
                case ($urandom_range(9))
                    0: send_random_set($urandom_range(1, 6), 0);
                    1, 2: send_random_set($urandom_range(2, 12), $urandom_range(1, 3));
                    default: send_random_set($urandom_range(2, 12), -1);
                endcase
            end
        end
        @(negedge i_clk);
        i_s_tvalid = 0;
        i_s_tlast = 0;

        while (sb.fits_due.size() != 0) @(posedge i_clk);
        repeat (FIT_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.fits_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### sim.f
rtl/slr_pkg.sv
rtl/slr_ctrl.sv
rtl/slr_dp.sv
rtl/simple_linear_regression_core.sv
bench/testbench.sv
